>>> rtl/kmce_pkg.sv
package kmce_pkg;

	localparam int DEF_ROWS = 8;
	localparam int DEF_COLS = 16;

	localparam int ROW_W = 3;
	localparam int COL_W = 4;
	localparam int BITS_W = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_ROW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_COL = 2'd2;

	localparam logic SPECIAL_EN_RST = 1'b1;
	localparam logic [ROW_W-1:0] SPECIAL_ROW_RST = 3'd4;
	localparam logic [COL_W-1:0] SPECIAL_COL_RST = 4'd10;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic en;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic pressed;
	} result_t;

	typedef struct packed {
		logic push;
		logic flush;
	} flow_t;

endpackage

>>> rtl/kmce_scan.sv
module kmce_scan #(
	parameter int ROWS = kmce_pkg::DEF_ROWS,
	parameter int COLS = kmce_pkg::DEF_COLS
) (
	input  logic clk,
	input  logic arst_n,
	input  kmce_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  logic [kmce_pkg::ROW_W-1:0] row_index,
	input  logic [kmce_pkg::BITS_W-1:0] row_bits,
	input  logic scan_end,
	output kmce_pkg::flow_t flow,
	output kmce_pkg::result_t res,
	input  logic flow_ok
);

	localparam int EFF_COLS = (COLS < kmce_pkg::BITS_W) ? COLS : kmce_pkg::BITS_W;
	localparam int EFF_ROWS = (ROWS < 8) ? ROWS : 8;
	localparam int IDX_W = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;
	localparam int CNT_W = (EFF_COLS > 1) ? $clog2(EFF_COLS) : 1;
	localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(EFF_COLS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COLS = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [EFF_COLS-1:0] rows_q [EFF_ROWS];
	logic [EFF_COLS-1:0] bits_q;
	logic [EFF_COLS-1:0] prev_q;
	logic [EFF_COLS-1:0] prev_next;
	logic [kmce_pkg::ROW_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic row_ok_q;
	logic end_q;
	logic skip_q;
	logic pending_q;

	logic accept;
	logic in_range;
	logic chg;
	logic special;
	logic new_bit;
	logic report_due;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign in_range = (32'(row_index) < ROWS);

	assign chg = (bits_q[0] ^ prev_q[0]) && !skip_q;
	assign special = chg && cfg.en && (row_q == cfg.row) && (kmce_pkg::COL_W'(col_q) == cfg.col);
	assign new_bit = (chg && !special) ? bits_q[0] : prev_q[0];
	assign report_due = end_q && pending_q;

	always_comb begin
		prev_next = prev_q >> 1;
		prev_next[EFF_COLS-1] = new_bit;
	end

	always_comb begin
		flow.push = 1'b0;
		flow.flush = 1'b0;
		res.kind = kmce_pkg::KIND_EVENT;
		res.row = row_q;
		res.col = kmce_pkg::COL_W'(col_q);
		res.pressed = bits_q[0];
		unique case (state_q)
			ST_COLS: begin
				flow.push = chg;
			end
			ST_REPORT: begin
				flow.push = report_due;
				res.kind = kmce_pkg::KIND_REPORT;
				res.row = '0;
				res.col = '0;
				res.pressed = 1'b0;
			end
			ST_FLUSH: begin
				flow.flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pending_q <= 1'b0;
			skip_q <= 1'b0;
			col_q <= '0;
			for (int i = 0; i < EFF_ROWS; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						skip_q <= !in_range;
						col_q <= '0;
						state_q <= ST_COLS;
					end
				end
				ST_COLS: begin
					if (flow_ok) begin
						if (chg) begin
							pending_q <= !special;
						end
						if (special) begin
							skip_q <= 1'b1;
						end
						col_q <= col_q + 1'b1;
						if (col_q == LAST_COL) begin
							if (row_ok_q) begin
								rows_q[row_q[IDX_W-1:0]] <= prev_next;
							end
							state_q <= ST_REPORT;
						end
					end
				end
				ST_REPORT: begin
					if (!report_due || flow_ok) begin
						if (report_due) begin
							pending_q <= 1'b0;
						end
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (flow_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// column shift registers, one column per step
	always_ff @(posedge clk) begin
		if (accept) begin
			bits_q <= row_bits[EFF_COLS-1:0];
			prev_q <= in_range ? rows_q[row_index[IDX_W-1:0]] : '0;
			row_q <= row_index;
			row_ok_q <= in_range;
			end_q <= scan_end;
		end else if (state_q == ST_COLS && flow_ok) begin
			bits_q <= bits_q >> 1;
			prev_q <= prev_next;
		end
	end

endmodule

>>> rtl/kmce_out.sv
module kmce_out (
	input  logic clk,
	input  logic arst_n,
	input  kmce_pkg::flow_t flow,
	input  kmce_pkg::result_t res,
	output logic flow_ok,
	output logic out_valid,
	input  logic out_stall,
	output logic item_kind,
	output logic [kmce_pkg::ROW_W-1:0] event_row,
	output logic [kmce_pkg::COL_W-1:0] event_col,
	output logic event_pressed,
	output logic run_last
);

	// one result is held back until the next one, or the end of the row, tells run_last
	logic hold_v_q;
	kmce_pkg::result_t hold_q;
	logic out_v_q;
	kmce_pkg::result_t out_q;
	logic last_q;
	logic load_out;

	assign flow_ok = !hold_v_q || !out_v_q || !out_stall;
	assign load_out = flow_ok && hold_v_q && (flow.push || flow.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (flow.push && flow_ok) begin
				hold_v_q <= 1'b1;
			end else if (flow.flush && flow_ok) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= hold_q;
			last_q <= flow.flush;
		end
		if (flow.push && flow_ok) begin
			hold_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign item_kind = out_q.kind;
	assign event_row = out_q.row;
	assign event_col = out_q.col;
	assign event_pressed = out_q.pressed;
	assign run_last = last_q;

endmodule

>>> rtl/key_matrix_change_events.sv
// Key matrix change events. Each input beat carries one scanned row; the row is compared
// with its stored previous state one column per cycle while the output is not stalled, lowest
// column first, and every change gives a key event beat (row, column, pressed) and is recorded,
// except the configured special key, whose event is given but not recorded, ending the row and
// clearing the pending flag. On a row flagged scan_end a send-report beat follows if a change is
// pending. run_last marks the final beat of each row. A new row is taken only after the current
// one has passed its column, report and flush steps. The row store is cleared by reset.
// Configuration must be written only while the block is idle; the block itself does not enforce this.
module key_matrix_change_events #(
	parameter int ROWS = kmce_pkg::DEF_ROWS,
	parameter int COLS = kmce_pkg::DEF_COLS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [kmce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kmce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [kmce_pkg::ROW_W-1:0] row_index,
	input  logic [kmce_pkg::BITS_W-1:0] row_bits,
	input  logic scan_end,
	output logic out_valid,
	input  logic out_stall,
	output logic item_kind,
	output logic [kmce_pkg::ROW_W-1:0] event_row,
	output logic [kmce_pkg::COL_W-1:0] event_col,
	output logic event_pressed,
	output logic run_last
);

	kmce_pkg::cfg_t cfg_q;
	kmce_pkg::flow_t flow;
	kmce_pkg::result_t res;
	logic flow_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.en <= kmce_pkg::SPECIAL_EN_RST;
			cfg_q.row <= kmce_pkg::SPECIAL_ROW_RST;
			cfg_q.col <= kmce_pkg::SPECIAL_COL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmce_pkg::REG_SPECIAL_ENABLE: cfg_q.en <= cfg_data[0];
				kmce_pkg::REG_SPECIAL_ROW: cfg_q.row <= cfg_data[kmce_pkg::ROW_W-1:0];
				kmce_pkg::REG_SPECIAL_COL: cfg_q.col <= cfg_data[kmce_pkg::COL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	kmce_scan #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.row_index(row_index),
		.row_bits(row_bits),
		.scan_end(scan_end),
		.flow(flow),
		.res(res),
		.flow_ok(flow_ok)
	);

	kmce_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.flow(flow),
		.res(res),
		.flow_ok(flow_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_kind(item_kind),
		.event_row(event_row),
		.event_col(event_col),
		.event_pressed(event_pressed),
		.run_last(run_last)
	);

endmodule

>>> rtl/kmce_check.sv
module kmce_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic item_kind,
	input logic [kmce_pkg::ROW_W-1:0] event_row,
	input logic [kmce_pkg::COL_W-1:0] event_col,
	input logic event_pressed,
	input logic run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_kind) && $stable(event_row)
			&& $stable(event_col) && $stable(event_pressed) && $stable(run_last))
		else $error("stalled output beat changed");

	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second row taken while one is in work");

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == kmce_pkg::KIND_REPORT |->
			event_row == '0 && event_col == '0 && !event_pressed)
		else $error("report beat with nonzero key fields");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == kmce_pkg::KIND_REPORT |-> run_last)
		else $error("report beat not last of its row");

endmodule

bind key_matrix_change_events kmce_check u_check (.*);
